### rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg: shared definitions for the ising metropolis spin update
// field widths, register indexes and controller states
// ----------------------------------------------------------------------------
package isu_pkg;

	localparam int ISU_SIDE   = 32;
	localparam int ROW_W      = 5;
	localparam int RAND_W     = 16;
	localparam int CHANGE_W   = 4;
	localparam int TOTAL_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int THR_NUM    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_THR_E1 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_THR_E2 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_THR_E3 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_THR_E4 = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC
	} isu_state_t;

endpackage

### rtl/isu_if.sv
// ----------------------------------------------------------------------------
// isu_if: channel interfaces of the spin update block
// proposal beats in, result beats out, configuration writes in
// ----------------------------------------------------------------------------
interface isu_item_if;
	import isu_pkg::*;
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  site_row;
	logic [ROW_W-1:0]  site_col;
	logic [RAND_W-1:0] accept_rand;
	modport source (output valid, output site_row, output site_col, output accept_rand,
		input ready);
	modport sink (input valid, input site_row, input site_col, input accept_rand,
		output ready);
endinterface

interface isu_result_if;
	import isu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       flip_accepted;
	logic                       site_spin;
	logic signed [CHANGE_W-1:0] energy_change;
	logic signed [TOTAL_W-1:0]  spin_total;
	modport source (output valid, output flip_accepted, output site_spin,
		output energy_change, output spin_total, input ready);
	modport sink (input valid, input flip_accepted, input site_spin,
		input energy_change, input spin_total, output ready);
endinterface

interface isu_cfg_if;
	import isu_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/isu_row_mem.sv
// ----------------------------------------------------------------------------
// isu_row_mem: lattice row memory
// one write port, two read ports, read data registered
// ----------------------------------------------------------------------------
module isu_row_mem #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

### rtl/ising_metropolis_spin_update_top.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_top: metropolis spin flip on a square lattice
// open boundaries, Q0.16 acceptance thresholds, running spin sum
// ----------------------------------------------------------------------------
// a proposal and its row reads are registered on acceptance, evaluated in
//   ST_CALC and its result registered once the result register is free
// one proposal at a time, set by the read-modify-write of the even/odd row
//   memories (read all five spins, write the center row back)
// reset: thresholds 0, spin sum SIDE*SIDE, then a clearing pass sets every
//   spin to +1; no proposal is taken during the pass, configuration writes are
module ising_metropolis_spin_update_top #(
	parameter int SIDE = isu_pkg::ISU_SIDE
) (
	input  logic         clk,
	input  logic         arst_n,
	isu_item_if.sink     item,
	isu_result_if.source result,
	isu_cfg_if.sink      cfg
);
	import isu_pkg::*;

	localparam int DEPTH_E = (SIDE + 1) / 2;
	localparam int DEPTH_O = SIDE / 2;
	localparam int AE      = (DEPTH_E > 1) ? $clog2(DEPTH_E) : 1;
	localparam int AO      = (DEPTH_O > 1) ? $clog2(DEPTH_O) : 1;
	localparam int CIW     = $clog2(SIDE);
	localparam int SUM_W   = $clog2(SIDE * SIDE + 1) + 1;
	localparam logic SUM_PAR = ((SIDE * SIDE) % 2) != 0;

	typedef logic [SIDE-1:0] word_t;

	isu_state_t state_q, state_nx;

	logic [AE-1:0]           clr_cnt_q;
	logic                    clr_last;
	logic                    in_ready;
	logic                    in_acc;
	logic                    clr_wr;
	logic                    fire;

	logic [RAND_W-1:0]       thr_q [THR_NUM];
	logic signed [SUM_W-1:0] sum_q, sum_nx;

	logic [ROW_W-1:0]        row_s1, col_s1;
	logic [RAND_W-1:0]       rand_s1;
	logic                    ok_s1;

	logic                    out_v_q;
	logic                    out_acc_q, out_spin_q;
	logic signed [CHANGE_W-1:0] out_chg_q;
	logic signed [TOTAL_W-1:0]  out_tot_q;

	logic [ROW_W-1:0]        r_in, c_in, rm1_in;
	logic [ROW_W:0]          rp1_in;
	logic                    ok_in, dn_in;
	logic [AE-1:0]           e_ra, e_rb, e_wa;
	logic [AO-1:0]           o_ra, o_rb, o_wa;
	logic                    e_we, o_we;
	word_t                   e_wd, o_wd;
	word_t                   e_da, e_db, o_da, o_db;

	word_t                   cw, uw, dw, nw, hot;
	logic [CIW-1:0]          ci, cl, cr;
	logic                    old, up_ok, dn_ok, lf_ok, rt_ok;
	logic signed [CHANGE_W-1:0] nsum, chg, chg_m1;
	logic [RAND_W-1:0]       thr_sel;
	logic                    acc, spin_nx;

	function automatic logic signed [CHANGE_W-1:0] contrib(input logic ok, input logic s);
		logic signed [CHANGE_W-1:0] v;
		v = '0;
		if (ok) begin
			v = s ? CHANGE_W'(1) : -CHANGE_W'(1);
		end
		return v;
	endfunction

	// controller
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_nx = ST_IDLE;
			ST_IDLE:  if (in_acc) state_nx = ST_CALC;
			ST_CALC:  if (fire) state_nx = ST_IDLE;
			default:  state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		clr_wr   = 1'b0;
		fire     = 1'b0;
		case (state_q)
			ST_CLEAR: clr_wr = 1'b1;
			ST_IDLE:  in_ready = 1'b1;
			ST_CALC:  fire = !out_v_q || result.ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign in_acc     = item.valid && in_ready;
	assign item.ready = in_ready;
	assign clr_last   = clr_cnt_q == AE'(DEPTH_E - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (clr_wr) begin
				clr_cnt_q <= clr_cnt_q + AE'(1);
			end
		end
	end

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THR_NUM; i++) begin
				thr_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_THR_E1: thr_q[0] <= cfg.data;
				CFG_THR_E2: thr_q[1] <= cfg.data;
				CFG_THR_E3: thr_q[2] <= cfg.data;
				CFG_THR_E4: thr_q[3] <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// read addresses: center row from its parity memory, rows above and below
	// from the other one
	always_comb begin
		r_in   = item.site_row;
		c_in   = item.site_col;
		rm1_in = r_in - ROW_W'(1);
		rp1_in = {1'b0, r_in} + (ROW_W + 1)'(1);
		ok_in  = (int'(r_in) < SIDE) && (int'(c_in) < SIDE);
		dn_in  = ok_in && (int'(rp1_in) < SIDE);
		e_ra   = '0;
		e_rb   = '0;
		o_ra   = '0;
		o_rb   = '0;
		if (ok_in) begin
			if (r_in[0]) begin
				o_ra = AO'(r_in >> 1);
				e_ra = AE'(rm1_in >> 1);
				if (dn_in) e_rb = AE'(rp1_in >> 1);
			end else begin
				e_ra = AE'(r_in >> 1);
				if (r_in != '0) o_ra = AO'(rm1_in >> 1);
				if (dn_in) o_rb = AO'(rp1_in >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_s1  <= item.site_row;
			col_s1  <= item.site_col;
			rand_s1 <= item.accept_rand;
			ok_s1   <= ok_in;
		end
	end

	// spin evaluation on the read rows
	always_comb begin
		cw     = row_s1[0] ? o_da : e_da;
		uw     = row_s1[0] ? e_da : o_da;
		dw     = row_s1[0] ? e_db : o_db;
		ci     = CIW'(col_s1);
		cl     = CIW'(col_s1 - ROW_W'(1));
		cr     = CIW'({1'b0, col_s1} + (ROW_W + 1)'(1));
		up_ok  = row_s1 != '0;
		dn_ok  = (int'(row_s1) + 1) < SIDE;
		lf_ok  = col_s1 != '0;
		rt_ok  = (int'(col_s1) + 1) < SIDE;
		old    = cw[ci];
		nsum   = contrib(up_ok, uw[ci]) + contrib(dn_ok, dw[ci])
			+ contrib(lf_ok, lf_ok && cw[cl]) + contrib(rt_ok, rt_ok && cw[cr]);
		chg    = '0;
		if (ok_s1) begin
			chg = old ? nsum : -nsum;
		end
		chg_m1  = chg - CHANGE_W'(1);
		thr_sel = thr_q[chg_m1[1:0]];
		acc     = ok_s1 && ((chg <= 0) || (rand_s1 <= thr_sel));
		spin_nx = ok_s1 && (acc ? !old : old);
		hot     = '0;
		hot[ci] = 1'b1;
		nw      = cw ^ hot;
		sum_nx  = sum_q;
		if (acc) begin
			sum_nx = old ? sum_q - SUM_W'(2) : sum_q + SUM_W'(2);
		end
	end

	// write back: clearing pass or the updated center row
	always_comb begin
		if (clr_wr) begin
			e_we = 1'b1;
			o_we = int'(clr_cnt_q) < DEPTH_O;
			e_wa = clr_cnt_q;
			o_wa = AO'(clr_cnt_q);
			e_wd = '1;
			o_wd = '1;
		end else begin
			e_we = fire && acc && !row_s1[0];
			o_we = fire && acc && row_s1[0];
			e_wa = AE'(row_s1 >> 1);
			o_wa = AO'(row_s1 >> 1);
			e_wd = nw;
			o_wd = nw;
		end
	end

	isu_row_mem #(.WIDTH(SIDE), .DEPTH(DEPTH_E), .AW(AE)) u_even_mem (
		.clk       (clk),
		.rd_en     (in_acc),
		.rd_addr_a (e_ra),
		.rd_addr_b (e_rb),
		.rd_data_a (e_da),
		.rd_data_b (e_db),
		.wr_en     (e_we),
		.wr_addr   (e_wa),
		.wr_data   (e_wd)
	);

	isu_row_mem #(.WIDTH(SIDE), .DEPTH(DEPTH_O), .AW(AO)) u_odd_mem (
		.clk       (clk),
		.rd_en     (in_acc),
		.rd_addr_a (o_ra),
		.rd_addr_b (o_rb),
		.rd_data_a (o_da),
		.rd_data_b (o_db),
		.wr_en     (o_we),
		.wr_addr   (o_wa),
		.wr_data   (o_wd)
	);

	// spin sum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= SUM_W'(SIDE * SIDE);
			out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				sum_q   <= sum_nx;
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_acc_q  <= acc;
			out_spin_q <= spin_nx;
			out_chg_q  <= chg;
			out_tot_q  <= TOTAL_W'(sum_nx);
		end
	end

	assign result.valid         = out_v_q;
	assign result.flip_accepted = out_acc_q;
	assign result.site_spin     = out_spin_q;
	assign result.energy_change = out_chg_q;
	assign result.spin_total    = out_tot_q;

	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> (state_q == ST_CALC))
		else $error("accepted beat did not start evaluation");

	a_calc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && result.valid && !result.ready) |=> (state_q == ST_CALC))
		else $error("evaluation finished into a full result register");

	a_sum_parity: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q[0] == SUM_PAR)
		else $error("spin sum changed by an odd amount");

	a_reject_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.flip_accepted && result.energy_change <= 0)
		|-> (result.energy_change == 0 && !result.site_spin))
		else $error("flip rejected at non-positive energy change");

endmodule
